FILE: rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// UV sphere vertex generator - shared package
// Payload types, fixed-point constants and rounding helpers used by the
// divider, the sine/cosine unit and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package uvs_pkg;

  // Configuration register indexes
  localparam logic CFG_LAT = 1'b0;
  localparam logic CFG_LON = 1'b1;

  // Reset values of the band counts
  localparam logic [10:0] LAT_RESET = 11'd16;
  localparam logic [11:0] LON_RESET = 12'd32;

  // Divider geometry: four lanes, 45-bit dividend, 12-bit divisor, 33 quotient bits
  localparam int DIV_LANES = 4;
  localparam int NUM_W     = 45;
  localparam int DEN_W     = 12;
  localparam int QUO_W     = 33;
  localparam int DIV_LAT   = QUO_W;

  // Lane assignment
  localparam int LANE_POLAR = 0;
  localparam int LANE_AZIM  = 1;
  localparam int LANE_TEXU  = 2;
  localparam int LANE_TEXV  = 3;

  // Sine/cosine unit latency
  localparam int SC_LAT = 13;

  // pi in Q32, split for two narrow multipliers
  localparam logic [33:0] PI_Q32 = 34'h3243F6A89;
  localparam logic [16:0] PI_HI  = PI_Q32[33:17];
  localparam logic [16:0] PI_LO  = PI_Q32[16:0];

  // Factorial step divisors of the series and their ceil(log2)
  localparam int SIN_DIV [4] = '{6, 20, 42, 72};
  localparam int SIN_LOG [4] = '{3, 5, 6, 7};
  localparam int COS_DIV [4] = '{12, 30, 56, 90};
  localparam int COS_LOG [4] = '{4, 5, 6, 7};

  typedef struct packed {
    logic [10:0] row_index;
    logic [11:0] column_index;
  } vtx_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [14:0]        tex_u;
    logic [14:0]        tex_v;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_z;
    logic signed [15:0] bitangent_x;
    logic signed [15:0] bitangent_y;
    logic signed [15:0] bitangent_z;
    logic               bad_index;
  } attr_t;

  // One divider stage: partial remainders and quotients of all lanes
  typedef struct packed {
    logic [DIV_LANES-1:0][NUM_W-1:0] rem;
    logic [DIV_LANES-1:0][QUO_W-1:0] quo;
    logic                            bad;
  } div_stage_t;

  // Data that rides beside the sine/cosine unit
  typedef struct packed {
    logic [14:0] tex_u;
    logic [14:0] tex_v;
    logic        bad;
  } side_t;

  // Q62 product to Q31, half away from zero
  function automatic logic signed [32:0] rnd31(input logic signed [65:0] v);
    logic [65:0] mag;
    logic [65:0] m;
    mag = v[65] ? 66'(-v) : 66'(v);
    m   = (mag + (66'(1) << 30)) >> 31;
    return v[65] ? -$signed(m[32:0]) : $signed(m[32:0]);
  endfunction

  // Q31 to Q2.14, half away from zero, 16-bit result
  function automatic logic [15:0] rnd17(input logic signed [32:0] v);
    logic [32:0] mag;
    logic [32:0] m;
    mag = v[32] ? 33'(-v) : 33'(v);
    m   = (mag + (33'(1) << 16)) >> 17;
    return v[32] ? 16'(-m) : 16'(m);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/uvs_divider.sv
// ----------------------------------------------------------------------------
// UV sphere - pipelined restoring divider
// Four lanes share the stage structure; each stage resolves one quotient
// bit, most significant first, with one compare and subtract per lane.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_divider (
  input  wire logic                                              clk,
  input  wire logic                                              rst,
  input  wire logic                                              en,
  input  wire logic                                              num_valid,
  input  wire logic [uvs_pkg::DIV_LANES-1:0][uvs_pkg::NUM_W-1:0] num,
  input  wire logic [uvs_pkg::DIV_LANES-1:0][uvs_pkg::DEN_W-1:0] den,
  input  wire logic                                              num_bad,
  output logic                                                   quo_valid,
  output logic [uvs_pkg::DIV_LANES-1:0][uvs_pkg::QUO_W-1:0]      quo,
  output logic                                                   quo_bad
);
  import uvs_pkg::*;

  logic       vld [0:DIV_LAT-1];
  div_stage_t stg [0:DIV_LAT-1];

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_stage
    localparam int BIT = QUO_W - 1 - i;
    div_stage_t prev;
    div_stage_t stg_next;
    logic       prev_v;

    // stage input: ports for the first stage, previous stage otherwise
    if (i == 0) begin : g_first
      always_comb begin
        prev.rem = num;
        prev.quo = '0;
        prev.bad = num_bad;
      end
      assign prev_v = num_valid;
    end else begin : g_rest
      assign prev   = stg[i-1];
      assign prev_v = vld[i-1];
    end

    // one quotient bit per lane
    always_comb begin
      logic [NUM_W-1:0] dsh;
      stg_next = prev;
      for (int l = 0; l < DIV_LANES; l++) begin
        dsh = NUM_W'(den[l]) << BIT;
        if (prev.rem[l] >= dsh) begin
          stg_next.rem[l] = prev.rem[l] - dsh;
          stg_next.quo[l] = prev.quo[l] | (QUO_W'(1) << BIT);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[i] <= stg_next;
      end
    end
  end

  assign quo_valid = vld[DIV_LAT-1];
  assign quo       = stg[DIV_LAT-1].quo;
  assign quo_bad   = stg[DIV_LAT-1].bad;

endmodule

`default_nettype wire

FILE: rtl/uvs_sincos.sv
// ----------------------------------------------------------------------------
// UV sphere - pipelined sine/cosine
// Octant fold, phase to radians, then Taylor series in Q31 with one
// multiply and one reciprocal divide stage per term; octant symmetry last.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_sincos (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               ph_valid,
  input  wire logic [31:0]        phase,
  output logic                    sc_valid,
  output logic signed [32:0]      sin_q31,
  output logic signed [32:0]      cos_q31
);
  import uvs_pkg::*;

  // fold stage
  logic        v0;
  logic [2:0]  oct0;
  logic [29:0] r0;
  // radian multiply stage
  logic        v1;
  logic [2:0]  oct1;
  logic [46:0] m_hi;
  logic [46:0] m_lo;
  // radian stage
  logic        v2;
  logic [2:0]  oct2;
  logic [30:0] xr;
  // series step boundaries, index 0 is the square stage
  logic               stp_v   [0:4];
  logic [2:0]         stp_oct [0:4];
  logic [30:0]        stp_xsq [0:4];
  logic [30:0]        stp_ts  [0:4];
  logic [30:0]        stp_tc  [0:4];
  logic signed [33:0] stp_s   [0:4];
  logic signed [33:0] stp_c   [0:4];
  // output
  logic               vo;
  logic signed [32:0] so;
  logic signed [32:0] co;

  logic [28:0] low;
  logic [64:0] xsum;
  logic [62:0] xx;
  logic [30:0] xsq;

  assign low  = phase[28:0];
  assign xsum = (65'(m_hi) << 17) + 65'(m_lo) + (65'(1) << 31);
  assign xx   = 63'(62'(xr) * 62'(xr)) + (63'(1) << 30);
  assign xsq  = xx[61:31];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      stp_v[0] <= 1'b0;
    end else if (en) begin
      v0       <= ph_valid;
      v1       <= v0;
      v2       <= v1;
      stp_v[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // fold to an offset within the octant
      oct0 <= phase[31:29];
      r0   <= phase[29] ? (30'h2000_0000 - 30'(low)) : 30'(low);
      // r * pi, split in two
      oct1 <= oct0;
      m_hi <= 47'(r0) * 47'(PI_HI);
      m_lo <= 47'(r0) * 47'(PI_LO);
      // radians in Q31
      oct2 <= oct1;
      xr   <= xsum[62:32];
      // square, seed both series
      stp_oct[0] <= oct2;
      stp_xsq[0] <= xsq;
      stp_ts[0]  <= xr;
      stp_tc[0]  <= xsq >> 1;
      stp_s[0]   <= 34'(xr);
      stp_c[0]   <= 34'sh8000_0000 - 34'(xsq >> 1);
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_term
    localparam int          SS = 31 + SIN_LOG[k];
    localparam int          CS = 31 + COS_LOG[k];
    localparam logic [31:0] MS = 32'(((64'd1 << SS) + 64'(SIN_DIV[k]) - 64'd1)
                                     / 64'(SIN_DIV[k]));
    localparam logic [31:0] MC = 32'(((64'd1 << CS) + 64'(COS_DIV[k]) - 64'd1)
                                     / 64'(COS_DIV[k]));

    logic               mv;
    logic [2:0]         moct;
    logic [30:0]        mxsq;
    logic [30:0]        mps;
    logic [30:0]        mpc;
    logic signed [33:0] ms;
    logic signed [33:0] mc;

    logic [61:0] ps_full;
    logic [61:0] pc_full;
    logic [62:0] qs_full;
    logic [62:0] qc_full;
    logic [30:0] ts;
    logic [30:0] tc;

    // product with x^2, rounded to Q31
    assign ps_full = 62'(stp_ts[k]) * 62'(stp_xsq[k]) + (62'(1) << 30);
    assign pc_full = 62'(stp_tc[k]) * 62'(stp_xsq[k]) + (62'(1) << 30);
    // exact floor division by the factorial step
    assign qs_full = (63'(mps) * 63'(MS)) >> SS;
    assign qc_full = (63'(mpc) * 63'(MC)) >> CS;
    assign ts      = qs_full[30:0];
    assign tc      = qc_full[30:0];

    always_ff @(posedge clk) begin
      if (rst) begin
        mv         <= 1'b0;
        stp_v[k+1] <= 1'b0;
      end else if (en) begin
        mv         <= stp_v[k];
        stp_v[k+1] <= mv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        moct <= stp_oct[k];
        mxsq <= stp_xsq[k];
        mps  <= ps_full[61:31];
        mpc  <= pc_full[61:31];
        ms   <= stp_s[k];
        mc   <= stp_c[k];

        stp_oct[k+1] <= moct;
        stp_xsq[k+1] <= mxsq;
        stp_ts[k+1]  <= ts;
        stp_tc[k+1]  <= tc;
        // alternating signs; cosine runs one term ahead
        stp_s[k+1]   <= (k % 2 == 0) ? ms - 34'(ts) : ms + 34'(ts);
        stp_c[k+1]   <= (k % 2 == 0) ? mc + 34'(tc) : mc - 34'(tc);
      end
    end
  end

  // clamp to [0, 1] and apply octant symmetry
  logic [31:0]        sclamp;
  logic [31:0]        cclamp;
  logic signed [32:0] sb;
  logic signed [32:0] cb;
  logic signed [32:0] sv;
  logic signed [32:0] cv;

  always_comb begin
    if (stp_s[4] < 0) begin
      sclamp = '0;
    end else if (stp_s[4] > 34'sh8000_0000) begin
      sclamp = 32'h8000_0000;
    end else begin
      sclamp = stp_s[4][31:0];
    end
    if (stp_c[4] < 0) begin
      cclamp = '0;
    end else if (stp_c[4] > 34'sh8000_0000) begin
      cclamp = 32'h8000_0000;
    end else begin
      cclamp = stp_c[4][31:0];
    end
    if (stp_oct[4][0]) begin
      sb = $signed({1'b0, cclamp});
      cb = $signed({1'b0, sclamp});
    end else begin
      sb = $signed({1'b0, sclamp});
      cb = $signed({1'b0, cclamp});
    end
    case (stp_oct[4][2:1])
      2'd0:    begin sv = sb;  cv = cb;  end
      2'd1:    begin sv = cb;  cv = -sb; end
      2'd2:    begin sv = -sb; cv = -cb; end
      default: begin sv = -cb; cv = sb;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= stp_v[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      so <= sv;
      co <= cv;
    end
  end

  assign sc_valid = vo;
  assign sin_q31  = so;
  assign cos_q31  = co;

endmodule

`default_nettype wire

FILE: rtl/uv_sphere_vertex_generator_core.sv
// ----------------------------------------------------------------------------
// UV sphere vertex generator - top level
// Usage: write lat_segments (index 0) and lon_segments (index 1) on the
// cfg_we/cfg_index/cfg_data port while the block is idle. Then send vertex
// beats (row_index, column_index) on vtx with vtx_valid; a beat is taken at
// a clock edge where vtx_valid is high and vtx_stall low. Each vertex gives
// one attr beat: normal, tangent, bitangent in Q2.14, texture u/v in Q1.14,
// and bad_index with all other fields zero for an out-of-range index or a zero band count.
// The pipeline is the bit-per-stage divider that forms the angle phases
// and texture coordinates, then the sine/cosine unit, then the product,
// rounding and output registers. One vertex per cycle is accepted while
// vtx_stall is low. When attr_stall holds a waiting result, the whole
// pipeline freezes and vtx_stall rises; nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline and loads 16 and 32.
// ----------------------------------------------------------------------------
`default_nettype none

module uv_sphere_vertex_generator_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [11:0]    cfg_data,
  input  wire logic           vtx_valid,
  output logic                vtx_stall,
  input  wire uvs_pkg::vtx_t  vtx,
  output logic                attr_valid,
  input  wire logic           attr_stall,
  output uvs_pkg::attr_t      attr
);
  import uvs_pkg::*;

  logic [10:0] lat_segments;
  logic [11:0] lon_segments;
  logic        en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lat_segments <= LAT_RESET;
      lon_segments <= LON_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LAT: lat_segments <= cfg_data[10:0];
        CFG_LON: lon_segments <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless a finished beat is held
  assign en        = !(attr_valid && attr_stall);
  assign vtx_stall = !en;

  // dividends, divisors and range check
  logic [DIV_LANES-1:0][NUM_W-1:0] num;
  logic [DIV_LANES-1:0][DEN_W-1:0] den;
  logic                            bad_in;

  always_comb begin
    num[LANE_POLAR] = (NUM_W'(vtx.row_index) << 32) + NUM_W'(lat_segments);
    num[LANE_AZIM]  = (NUM_W'(vtx.column_index) << 32) + NUM_W'(lon_segments >> 1);
    num[LANE_TEXU]  = (NUM_W'(vtx.column_index) << 14) + NUM_W'(lon_segments >> 1);
    num[LANE_TEXV]  = (NUM_W'(vtx.row_index) << 14) + NUM_W'(lat_segments >> 1);
    den[LANE_POLAR] = {lat_segments, 1'b0};
    den[LANE_AZIM]  = lon_segments;
    den[LANE_TEXU]  = lon_segments;
    den[LANE_TEXV]  = {1'b0, lat_segments};
    bad_in = (lat_segments == '0) || (lon_segments == '0) ||
             (vtx.row_index > lat_segments) || (vtx.column_index > lon_segments);
  end

  logic                            dq_valid;
  logic [DIV_LANES-1:0][QUO_W-1:0] dq;
  logic                            dq_bad;

  uvs_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .num_valid (vtx_valid),
    .num       (num),
    .den       (den),
    .num_bad   (bad_in),
    .quo_valid (dq_valid),
    .quo       (dq),
    .quo_bad   (dq_bad)
  );

  // polar and azimuth sine/cosine
  logic               pol_valid;
  logic               azi_valid;
  logic signed [32:0] st;
  logic signed [32:0] ct;
  logic signed [32:0] sp;
  logic signed [32:0] cp;

  uvs_sincos u_pol (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ph_valid (dq_valid),
    .phase    (dq[LANE_POLAR][31:0]),
    .sc_valid (pol_valid),
    .sin_q31  (st),
    .cos_q31  (ct)
  );

  uvs_sincos u_azi (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ph_valid (dq_valid),
    .phase    (dq[LANE_AZIM][31:0]),
    .sc_valid (azi_valid),
    .sin_q31  (sp),
    .cos_q31  (cp)
  );

  // texture and range flag ride alongside
  side_t side [0:SC_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= '{tex_u: dq[LANE_TEXU][14:0], tex_v: dq[LANE_TEXV][14:0], bad: dq_bad};
      for (int i = 1; i < SC_LAT; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // product stage
  logic               pv;
  side_t              pside;
  logic signed [32:0] p_st;
  logic signed [32:0] p_ct;
  logic signed [32:0] p_sp;
  logic signed [32:0] p_cp;
  logic signed [65:0] pr_stcp;
  logic signed [65:0] pr_stsp;
  logic signed [65:0] pr_ctcp;
  logic signed [65:0] pr_ctsp;
  // rounding stage
  logic               rv;
  side_t              rside;
  logic signed [32:0] r_st;
  logic signed [32:0] r_ct;
  logic signed [32:0] r_sp;
  logic signed [32:0] r_cp;
  logic signed [32:0] r_stcp;
  logic signed [32:0] r_stsp;
  logic signed [32:0] r_ctcp;
  logic signed [32:0] r_ctsp;
  // output register
  logic               ov;
  attr_t              obeat;
  attr_t              attr_next;

  always_comb begin
    if (rside.bad) begin
      attr_next           = '0;
      attr_next.bad_index = 1'b1;
    end else begin
      attr_next.normal_x    = rnd17(r_stcp);
      attr_next.normal_y    = rnd17(r_ct);
      attr_next.normal_z    = rnd17(r_stsp);
      attr_next.tex_u       = rside.tex_u;
      attr_next.tex_v       = rside.tex_v;
      attr_next.tangent_x   = rnd17(-r_sp);
      attr_next.tangent_z   = rnd17(r_cp);
      attr_next.bitangent_x = rnd17(r_ctcp);
      attr_next.bitangent_y = rnd17(-r_st);
      attr_next.bitangent_z = rnd17(r_ctsp);
      attr_next.bad_index   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
      rv <= 1'b0;
      ov <= 1'b0;
    end else if (en) begin
      pv <= pol_valid && azi_valid;
      rv <= pv;
      ov <= rv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pside   <= side[SC_LAT-1];
      p_st    <= st;
      p_ct    <= ct;
      p_sp    <= sp;
      p_cp    <= cp;
      pr_stcp <= 66'(st) * 66'(cp);
      pr_stsp <= 66'(st) * 66'(sp);
      pr_ctcp <= 66'(ct) * 66'(cp);
      pr_ctsp <= 66'(ct) * 66'(sp);

      rside  <= pside;
      r_st   <= p_st;
      r_ct   <= p_ct;
      r_sp   <= p_sp;
      r_cp   <= p_cp;
      r_stcp <= rnd31(pr_stcp);
      r_stsp <= rnd31(pr_stsp);
      r_ctcp <= rnd31(pr_ctcp);
      r_ctsp <= rnd31(pr_ctsp);

      obeat <= attr_next;
    end
  end

  assign attr_valid = ov;
  assign attr       = obeat;

endmodule

`default_nettype wire
